>>> rtl/tdm_pkg.sv
// tdm_pkg: shared codes and default sizes for the table-driven dfa matcher
// no dependencies; used by table_driven_dfa_matcher
package tdm_pkg;

    localparam int DEF_NUM_STATES  = 256;
    localparam int DEF_NUM_CLASSES = 64;

    localparam int CMD_W    = 3;
    localparam int STATE_W  = 8;
    localparam int CLASS_W  = 6;
    localparam int TOKEN_W  = 8;
    localparam int STATUS_W = 2;
    localparam int PADDR_W  = 3;
    localparam int PDATA_W  = 32;

    typedef logic [CMD_W-1:0]    t_cmd;
    typedef logic [STATUS_W-1:0] t_status;

    localparam t_cmd CMD_MAP   = 3'd0;
    localparam t_cmd CMD_TRANS = 3'd1;
    localparam t_cmd CMD_INFO  = 3'd2;
    localparam t_cmd CMD_BYTE  = 3'd3;
    localparam t_cmd CMD_END   = 3'd4;

    localparam t_status ST_ACCEPT   = 2'd0;
    localparam t_status ST_NOACCEPT = 2'd1;
    localparam t_status ST_NOCLASS  = 2'd2;
    localparam t_status ST_NOTRANS  = 2'd3;
    localparam t_status FAIL_NONE   = 2'd0;

    // register index (byte address bit 2 and up)
    localparam logic REG_START_STATE = 1'b0;

endpackage

>>> rtl/table_driven_dfa_matcher.sv
// table_driven_dfa_matcher: class map, transition table and state info stores
// with a one-byte-per-cycle matching pipeline; depends on tdm_pkg
//
// usage
// - input channel i_valid/o_ready carries one command per transaction: load the
//   class map, a transition or a state's accept flag and token, match a byte,
//   or end the string
// - output channel o_valid/i_ready carries one result per end-string command:
//   status, token and end state
// - apb port holds start_state at address 0; a write also restarts the string
// - one command is taken per cycle while o_ready is high; the transition table
//   is read at most once per byte; its registered read data addresses the next byte
// - o_valid rises once the end-string command's state info read is registered
// - after reset the transition and state info memories are swept clear with
//   o_ready low; the class map resets at once
// - when the receiver stalls, load and byte commands keep flowing, but the next
//   end-string command waits in the input stage and blocks every command behind it
module table_driven_dfa_matcher #(
    parameter int NUM_STATES  = tdm_pkg::DEF_NUM_STATES,
    parameter int NUM_CLASSES = tdm_pkg::DEF_NUM_CLASSES
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_ready,
    input  logic [tdm_pkg::CMD_W-1:0]     i_cmd,
    input  logic [7:0]                    i_byte_value,
    input  logic [tdm_pkg::STATE_W-1:0]   i_state_index,
    input  logic [tdm_pkg::CLASS_W-1:0]   i_class_id,
    input  logic                          i_entry_valid,
    input  logic [tdm_pkg::STATE_W-1:0]   i_next_state,
    input  logic                          i_accept_flag,
    input  logic [tdm_pkg::TOKEN_W-1:0]   i_token_in,
    output logic                          o_valid,
    input  logic                          i_ready,
    output logic [tdm_pkg::STATUS_W-1:0]  o_status,
    output logic [tdm_pkg::TOKEN_W-1:0]   o_token_out,
    output logic [tdm_pkg::STATE_W-1:0]   o_end_state,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [tdm_pkg::PADDR_W-1:0]   paddr,
    input  logic [tdm_pkg::PDATA_W-1:0]   pwdata,
    output logic [tdm_pkg::PDATA_W-1:0]   prdata,
    output logic                          pready
);

    localparam int SW     = $clog2(NUM_STATES);
    localparam int CW     = (NUM_CLASSES > 1) ? $clog2(NUM_CLASSES) : 1;
    localparam int TDEPTH = NUM_STATES * NUM_CLASSES;
    localparam int AW     = $clog2(TDEPTH);
    localparam int STW    = tdm_pkg::STATE_W;
    localparam int CLW    = tdm_pkg::CLASS_W;
    localparam int TKW    = tdm_pkg::TOKEN_W;

    function automatic logic [SW-1:0] st_ix(input logic [STW-1:0] s);
        logic [SW+STW-1:0] ext;
        ext = {{SW{1'b0}}, s};
        return ext[SW-1:0];
    endfunction

    function automatic logic [CW-1:0] cl_ix(input logic [CLW-1:0] c);
        logic [CW+CLW-1:0] ext;
        ext = {{CW{1'b0}}, c};
        return ext[CW-1:0];
    endfunction

    function automatic logic [AW-1:0] tr_addr(input logic [STW-1:0] s,
                                              input logic [CLW-1:0] c);
        return AW'(st_ix(s)) * AW'(NUM_CLASSES) + AW'(cl_ix(c));
    endfunction

    // memories
    logic [CLW-1:0]     r_map_mem  [256];
    logic [255:0]       r_map_vld;
    logic [STW:0]       r_tr_mem   [TDEPTH];
    logic [TKW:0]       r_info_mem [NUM_STATES];

    // control and stage registers
    logic               r_clr;
    logic [AW-1:0]      r_clr_cnt;
    logic [STW-1:0]     r_start;
    logic [STW-1:0]     r_cur;
    logic [1:0]         r_fail;
    logic               r_pend;

    logic               r_s1_vld;
    tdm_pkg::t_cmd      r_s1_cmd;
    logic [STW-1:0]     r_s1_si;
    logic [CLW-1:0]     r_s1_cid;
    logic               r_s1_ev;
    logic [STW-1:0]     r_s1_nxt;
    logic               r_s1_acc;
    logic [TKW-1:0]     r_s1_tok;
    logic [CLW-1:0]     r_map_rd;
    logic               r_map_hit;

    logic [STW:0]       r_tr_rd;
    logic [TKW:0]       r_info_rd;
    logic               r_o_vld;
    logic [1:0]         r_o_fail;
    logic [STW-1:0]     r_o_state;
    logic               r_o_inrange;

    logic               in_take;
    logic               out_take;
    logic               cfg_wr;
    logic               s1_end;
    logic               s1_go;
    logic [STW-1:0]     eff_state;
    logic [1:0]         eff_fail;
    logic               st_oor;
    logic               cls_oor;
    logic               tr_rd_en;
    logic               tr_we;
    logic [AW-1:0]      tr_waddr;
    logic [STW:0]       tr_wdata;
    logic               info_we;
    logic [SW-1:0]      info_waddr;
    logic [TKW:0]       info_wdata;
    logic               info_rd_en;
    logic [STW-1:0]     n_cur;
    logic [1:0]         n_fail;
    logic               n_pend;
    logic               accepted;

    assign pready   = 1'b1;
    assign prdata   = {{(tdm_pkg::PDATA_W-STW){1'b0}}, r_start};
    assign cfg_wr   = psel && penable && pwrite && pready &&
                      (paddr[tdm_pkg::PADDR_W-1:2] == tdm_pkg::REG_START_STATE);

    assign s1_end   = (r_s1_cmd == tdm_pkg::CMD_END);
    assign out_take = r_o_vld && i_ready;
    assign s1_go    = r_s1_vld && (!s1_end || !r_o_vld || i_ready);
    assign o_ready  = !r_clr && (!r_s1_vld || s1_go);
    assign in_take  = i_valid && o_ready;

    // resolve the transition read of the previous byte
    always_comb begin
        eff_state = r_cur;
        eff_fail  = r_fail;
        if (r_pend) begin
            if (r_tr_rd[STW]) begin
                eff_state = r_tr_rd[STW-1:0];
            end else begin
                eff_fail = tdm_pkg::ST_NOTRANS;
            end
        end
    end

    assign st_oor  = int'(eff_state) >= NUM_STATES;
    assign cls_oor = int'(r_map_rd) >= NUM_CLASSES;

    always_comb begin
        n_cur    = eff_state;
        n_fail   = eff_fail;
        n_pend   = 1'b0;
        tr_rd_en = 1'b0;
        if (s1_go) begin
            case (r_s1_cmd)
                tdm_pkg::CMD_BYTE: begin
                    if (eff_fail == tdm_pkg::FAIL_NONE) begin
                        if (!r_map_hit) begin
                            n_fail = tdm_pkg::ST_NOCLASS;
                        end else if (st_oor || cls_oor) begin
                            n_fail = tdm_pkg::ST_NOTRANS;
                        end else begin
                            n_pend   = 1'b1;
                            tr_rd_en = 1'b1;
                        end
                    end
                end
                tdm_pkg::CMD_END: begin
                    n_cur  = r_start;
                    n_fail = tdm_pkg::FAIL_NONE;
                end
                default: begin
                end
            endcase
        end
    end

    // store write ports, shared with the clearing sweep
    always_comb begin
        tr_we      = 1'b0;
        tr_waddr   = tr_addr(r_s1_si, r_s1_cid);
        tr_wdata   = r_s1_ev ? {1'b1, r_s1_nxt} : '0;
        info_we    = 1'b0;
        info_waddr = st_ix(r_s1_si);
        info_wdata = {r_s1_acc, r_s1_tok};
        if (r_clr) begin
            tr_we      = 1'b1;
            tr_waddr   = r_clr_cnt;
            tr_wdata   = '0;
            info_we    = int'(r_clr_cnt) < NUM_STATES;
            info_waddr = r_clr_cnt[SW-1:0];
            info_wdata = '0;
        end else if (s1_go) begin
            tr_we   = (r_s1_cmd == tdm_pkg::CMD_TRANS) &&
                      (int'(r_s1_si) < NUM_STATES) && (int'(r_s1_cid) < NUM_CLASSES);
            info_we = (r_s1_cmd == tdm_pkg::CMD_INFO) && (int'(r_s1_si) < NUM_STATES);
        end
    end

    assign info_rd_en = s1_go && s1_end;

    always_ff @(posedge i_clk) begin
        if (in_take && (i_cmd == tdm_pkg::CMD_MAP)) begin
            r_map_mem[i_byte_value] <= i_class_id;
        end
        if (in_take && (i_cmd == tdm_pkg::CMD_BYTE)) begin
            r_map_rd <= r_map_mem[i_byte_value];
        end
    end

    always_ff @(posedge i_clk) begin
        if (tr_we) begin
            r_tr_mem[tr_waddr] <= tr_wdata;
        end
        if (tr_rd_en) begin
            r_tr_rd <= r_tr_mem[tr_addr(eff_state, r_map_rd)];
        end
    end

    always_ff @(posedge i_clk) begin
        if (info_we) begin
            r_info_mem[info_waddr] <= info_wdata;
        end
        if (info_rd_en) begin
            r_info_rd <= r_info_mem[st_ix(eff_state)];
        end
    end

    // input stage payload and end-string result capture
    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_s1_cmd  <= i_cmd;
            r_s1_si   <= i_state_index;
            r_s1_cid  <= i_class_id;
            r_s1_ev   <= i_entry_valid;
            r_s1_nxt  <= i_next_state;
            r_s1_acc  <= i_accept_flag;
            r_s1_tok  <= i_token_in;
            r_map_hit <= r_map_vld[i_byte_value];
        end
        if (info_rd_en) begin
            r_o_fail    <= eff_fail;
            r_o_state   <= eff_state;
            r_o_inrange <= !st_oor;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr     <= 1'b1;
            r_clr_cnt <= '0;
            r_start   <= '0;
            r_cur     <= '0;
            r_fail    <= tdm_pkg::FAIL_NONE;
            r_pend    <= 1'b0;
            r_s1_vld  <= 1'b0;
            r_o_vld   <= 1'b0;
            r_map_vld <= '0;
        end else begin
            if (r_clr) begin
                r_clr_cnt <= r_clr_cnt + 1'b1;
                if (r_clr_cnt == AW'(TDEPTH - 1)) begin
                    r_clr <= 1'b0;
                end
            end
            if (in_take && (i_cmd == tdm_pkg::CMD_MAP)) begin
                r_map_vld[i_byte_value] <= i_entry_valid;
            end
            if (in_take) begin
                r_s1_vld <= 1'b1;
            end else if (s1_go) begin
                r_s1_vld <= 1'b0;
            end
            if (info_rd_en) begin
                r_o_vld <= 1'b1;
            end else if (out_take) begin
                r_o_vld <= 1'b0;
            end
            if (cfg_wr) begin
                r_start <= pwdata[STW-1:0];
                r_cur   <= pwdata[STW-1:0];
                r_fail  <= tdm_pkg::FAIL_NONE;
                r_pend  <= 1'b0;
            end else begin
                r_cur  <= n_cur;
                r_fail <= n_fail;
                r_pend <= n_pend;
            end
        end
    end

    // result formatting
    assign accepted    = (r_o_fail == tdm_pkg::FAIL_NONE) && r_o_inrange && r_info_rd[TKW];
    assign o_valid     = r_o_vld;
    assign o_end_state = r_o_state;
    assign o_token_out = accepted ? r_info_rd[TKW-1:0] : '0;
    assign o_status    = (r_o_fail != tdm_pkg::FAIL_NONE) ? r_o_fail :
                         (accepted ? tdm_pkg::ST_ACCEPT : tdm_pkg::ST_NOACCEPT);

    a_no_take_while_clearing : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_clr |-> !o_ready)
        else $error("command accepted during memory clear");

    a_pend_without_fail : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pend |-> (r_fail == tdm_pkg::FAIL_NONE))
        else $error("transition read pending after a failure");

    a_no_result_overwrite : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_o_vld && !i_ready) |=> (r_o_vld && $stable(r_o_state) && $stable(r_info_rd)))
        else $error("held result changed under stall");

endmodule
